@@ hw/rtl/wiegand_door_controller_core_macros.svh @@
// Assertion macros used by the checker file of the door controller
`ifndef WIEGAND_DOOR_CONTROLLER_CORE_MACROS_SVH
`define WIEGAND_DOOR_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define WDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define WDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/wdc_pkg.sv @@
// Package: constants, codes and types of the Wiegand door controller
package wdc_pkg;

    localparam int CHANNELS   = 6;
    localparam int FRAME_BITS = 26;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FIDX_W     = $clog2(FRAME_BITS);
    localparam int POS_W      = 6;
    localparam int CARD_W     = 24;
    localparam int LINE_W     = 6;
    localparam int KIND_W     = 2;
    localparam int CHAN_F_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [POS_W-1:0] POS_TOP  = POS_W'(FRAME_BITS - 1);
    localparam logic [POS_W-1:0] POS_DONE = '1;

    // Item kinds on the input channel
    typedef enum logic [KIND_W-1:0] {
        OP_D0    = 2'd0,
        OP_D1    = 2'd1,
        OP_TICK  = 2'd2,
        OP_GRANT = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAP_LIMIT = 2'd0,
        REG_OPEN      = 2'd1,
        REG_VOTES     = 2'd2,
        REG_NONE      = 2'd3
    } t_reg;

    // Result kinds
    localparam logic RPT_CARD   = 1'b0;
    localparam logic RPT_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] gap_limit_ticks;
        logic [7:0] open_ticks;
        logic [2:0] button_votes;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gap_limit_ticks: 8'd10,
        open_ticks:      8'd40,
        button_votes:    3'd4
    };

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame_word;
        logic [POS_W-1:0]      bit_position;
        logic                  frame_ready;
        logic [7:0]            idle_ticks;
        logic [4:0]            button_history;
        logic [7:0]            door_hold_count;
        logic                  door_line;
    } t_chan;

    localparam t_chan CHAN_RESET = '{
        frame_word:      '0,
        bit_position:    POS_TOP,
        frame_ready:     1'b0,
        idle_ticks:      8'd0,
        button_history:  5'd0,
        door_hold_count: 8'd0,
        door_line:       1'b0
    };

endpackage

@@ hw/rtl/wdc_if.sv @@
// Interfaces: item input, result output and configuration write channels

interface wdc_in_if;
    logic                          valid;
    logic                          ready;
    logic [wdc_pkg::KIND_W-1:0]    kind;
    logic [wdc_pkg::CHAN_F_W-1:0]  channel;
    logic [wdc_pkg::LINE_W-1:0]    button_levels;
    logic                          granted;

    modport source (output valid, kind, channel, button_levels, granted, input ready);
    modport sink   (input valid, kind, channel, button_levels, granted, output ready);
endinterface

interface wdc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          report_kind;
    logic [wdc_pkg::CHAN_F_W-1:0]  report_channel;
    logic [wdc_pkg::CARD_W-1:0]    card_number;
    logic [wdc_pkg::LINE_W-1:0]    door_lines;
    logic                          last;

    modport source (output valid, report_kind, report_channel, card_number, door_lines, last,
                    input ready);
    modport sink   (input valid, report_kind, report_channel, card_number, door_lines, last,
                    output ready);
endinterface

interface wdc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wdc_pkg::CFG_IDX_W-1:0]   index;
    logic [wdc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/wdc_chan_alu.sv @@
// Shared channel unit: next state of one reader channel for one operation
module wdc_chan_alu (
    input  wdc_pkg::t_op   i_op,
    input  wdc_pkg::t_cfg  i_cfg,
    input  wdc_pkg::t_chan i_cur,
    input  logic           i_button,
    input  logic           i_granted,
    output wdc_pkg::t_chan o_next
);

    logic [wdc_pkg::POS_W-1:0] pos;
    logic [4:0]                hist;
    logic [2:0]                votes;
    logic                      open;
    logic [7:0]                hold;
    logic                      line;

    always_comb begin
        o_next = i_cur;
        pos    = i_cur.bit_position;
        hist   = {i_cur.button_history[3:0], i_button};
        votes  = 3'($countones(hist));
        open   = 1'b0;
        hold   = i_cur.door_hold_count;
        line   = i_cur.door_line;

        unique case (i_op)
            wdc_pkg::OP_D0, wdc_pkg::OP_D1: begin
                // restart the frame after a long gap, then write the bit
                if (i_cur.idle_ticks > i_cfg.gap_limit_ticks) begin
                    pos = wdc_pkg::POS_TOP;
                end
                o_next.idle_ticks   = 8'd0;
                o_next.bit_position = pos;
                if (pos < wdc_pkg::POS_W'(wdc_pkg::FRAME_BITS)) begin
                    o_next.frame_word[pos[wdc_pkg::FIDX_W-1:0]] = (i_op == wdc_pkg::OP_D1);
                    if (pos == '0) begin
                        o_next.frame_ready  = 1'b1;
                        o_next.bit_position = wdc_pkg::POS_DONE;
                    end else begin
                        o_next.bit_position = pos - wdc_pkg::POS_W'(1);
                    end
                end
            end
            wdc_pkg::OP_TICK: begin
                // drop the report flag, age the channel, vote, count down
                o_next.frame_ready    = 1'b0;
                if (i_cur.idle_ticks != 8'hFF) begin
                    o_next.idle_ticks = i_cur.idle_ticks + 8'd1;
                end
                o_next.button_history = hist;
                open = (votes >= i_cfg.button_votes);
                if (open) begin
                    hold = i_cfg.open_ticks;
                    line = 1'b1;
                end
                if (hold != 8'd0) begin
                    hold = hold - 8'd1;
                    if (hold == 8'd0) begin
                        line = 1'b0;
                    end
                end
                o_next.door_hold_count = hold;
                o_next.door_line       = line;
            end
            wdc_pkg::OP_GRANT: begin
                if (i_granted) begin
                    o_next.door_hold_count = i_cfg.open_ticks;
                    o_next.door_line       = 1'b1;
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

endmodule

@@ hw/rtl/wiegand_door_controller_core.sv @@
// Top level: Wiegand 26-bit multi-channel receiver with door release control
//
//  channel | dir | payload                                               | transfer
//  i_in    | in  | kind, channel, button_levels, granted                 | valid & ready
//  o_out   | out | report_kind, report_channel, card_number,             | valid & ready
//          |     | door_lines, last                                      |
//  i_cfg   | in  | index, data                                           | valid & ready
//
// A pulse or access answer is handled as a transfer, then one pass through the channel unit.
// A poll tick runs one channel unit pass per channel, then a report scan that visits each
// channel in turn, then one status.
// Output back-pressure stalls the report scan and the status; i_in.ready is high
// only when idle.
// i_cfg is always ready. Reset (synchronous, active low) clears all channel state.
module wiegand_door_controller_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wdc_in_if.sink    i_in,
    wdc_out_if.source o_out,
    wdc_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_SWEEP,
        S_EMIT,
        S_STATUS
    } t_state;

    localparam logic [wdc_pkg::CH_W-1:0] IDX_LAST = wdc_pkg::CH_W'(wdc_pkg::CHANNELS - 1);

    t_state                         r_state;
    logic [wdc_pkg::CH_W-1:0]       r_idx;
    logic [wdc_pkg::CHANNELS-1:0]   r_mask;
    wdc_pkg::t_cfg                  r_cfg;
    wdc_pkg::t_chan                 r_chan [wdc_pkg::CHANNELS];

    wdc_pkg::t_op                   r_op;
    logic [wdc_pkg::CHAN_F_W-1:0]   r_channel;
    logic [wdc_pkg::LINE_W-1:0]     r_buttons;
    logic                           r_granted;

    logic                           r_out_valid;
    logic                           r_out_kind;
    logic [wdc_pkg::CHAN_F_W-1:0]   r_out_channel;
    logic [wdc_pkg::CARD_W-1:0]     r_out_card;
    logic [wdc_pkg::LINE_W-1:0]     r_out_lines;
    logic                           r_out_last;

    logic                           in_xfer;
    logic                           out_free;
    logic                           out_load;
    logic                           chan_ok;
    logic                           wr_en;
    logic [wdc_pkg::CH_W-1:0]       sel;
    logic                           button;
    wdc_pkg::t_op                   alu_op;
    wdc_pkg::t_chan                 alu_next;
    logic [wdc_pkg::LINE_W-1:0]     lines;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    // load the output register with a card report or the status
    assign out_load = out_free &&
                      (((r_state == S_EMIT) && r_mask[r_idx]) || (r_state == S_STATUS));

    // pick the channel the shared unit works on
    assign chan_ok = (r_channel < wdc_pkg::CHAN_F_W'(wdc_pkg::CHANNELS));
    assign sel     = (r_state == S_SWEEP) ? r_idx : r_channel[wdc_pkg::CH_W-1:0];
    assign alu_op  = (r_state == S_SWEEP) ? wdc_pkg::OP_TICK : r_op;
    assign button  = r_buttons[sel];
    assign wr_en   = (r_state == S_SWEEP) || ((r_state == S_ONE) && chan_ok);

    wdc_chan_alu u_alu (
        .i_op      (alu_op),
        .i_cfg     (r_cfg),
        .i_cur     (r_chan[sel]),
        .i_button  (button),
        .i_granted (r_granted),
        .o_next    (alu_next)
    );

    // gather the door lines of all channels
    always_comb begin
        lines = '0;
        for (int i = 0; i < wdc_pkg::LINE_W; i++) begin
            if (i < wdc_pkg::CHANNELS) begin
                lines[i] = r_chan[i].door_line;
            end
        end
    end

    // hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= wdc_pkg::CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (wdc_pkg::t_reg'(i_cfg.index))
                wdc_pkg::REG_GAP_LIMIT: r_cfg.gap_limit_ticks <= i_cfg.data;
                wdc_pkg::REG_OPEN:      r_cfg.open_ticks      <= i_cfg.data;
                wdc_pkg::REG_VOTES:     r_cfg.button_votes    <= i_cfg.data[2:0];
                default: begin
                end
            endcase
        end
    end

    // write back the channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wdc_pkg::CHANNELS; i++) begin
                r_chan[i] <= wdc_pkg::CHAN_RESET;
            end
        end else if (wr_en) begin
            r_chan[sel] <= alu_next;
        end
    end

    // latch the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op      <= wdc_pkg::t_op'(i_in.kind);
            r_channel <= i_in.channel;
            r_buttons <= i_in.button_levels;
            r_granted <= i_in.granted;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (in_xfer) begin
                        r_state <= (wdc_pkg::t_op'(i_in.kind) == wdc_pkg::OP_TICK) ?
                                   S_SWEEP : S_ONE;
                    end
                end
                S_ONE: begin
                    r_state <= S_IDLE;
                end
                S_SWEEP: begin
                    r_mask[r_idx] <= r_chan[r_idx].frame_ready;
                    if (r_idx == IDX_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + wdc_pkg::CH_W'(1);
                    end
                end
                S_EMIT: begin
                    if (!r_mask[r_idx] || out_free) begin
                        if (r_mask[r_idx]) begin
                            r_out_kind    <= wdc_pkg::RPT_CARD;
                            r_out_channel <= wdc_pkg::CHAN_F_W'(r_idx);
                            r_out_card    <= wdc_pkg::CARD_W'(
                                r_chan[r_idx].frame_word[wdc_pkg::FRAME_BITS-2:1]);
                            r_out_lines   <= lines;
                            r_out_last    <= 1'b0;
                        end
                        if (r_idx == IDX_LAST) begin
                            r_idx   <= '0;
                            r_state <= S_STATUS;
                        end else begin
                            r_idx <= r_idx + wdc_pkg::CH_W'(1);
                        end
                    end
                end
                S_STATUS: begin
                    if (out_free) begin
                        r_out_kind    <= wdc_pkg::RPT_STATUS;
                        r_out_channel <= '0;
                        r_out_card    <= '0;
                        r_out_lines   <= lines;
                        r_out_last    <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.report_kind    = r_out_kind;
    assign o_out.report_channel = r_out_channel;
    assign o_out.card_number    = r_out_card;
    assign o_out.door_lines     = r_out_lines;
    assign o_out.last           = r_out_last;

endmodule

@@ hw/rtl/wdc_checker.sv @@
// Checker on the top level's ports, attached by bind
`include "wiegand_door_controller_core_macros.svh"

module wdc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_kind,
    input logic [wdc_pkg::CHAN_F_W-1:0]  out_channel,
    input logic [wdc_pkg::CARD_W-1:0]    out_card,
    input logic [wdc_pkg::LINE_W-1:0]    out_lines,
    input logic                          out_last
);

    // a stalled result holds
    `WDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_card) && $stable(out_channel) && $stable(out_lines) && $stable(out_last), "stalled result changed")

    // only the status result ends a tick's run
    `WDC_ASSERT_NOW(a_last_status, out_valid, out_last == out_kind, "last and status disagree")

    // the status result carries no card
    `WDC_ASSERT_NOW(a_status_zero, out_valid && out_kind, out_channel == '0 && out_card == '0, "status result has card fields")

    // card reports name an existing channel
    `WDC_ASSERT_NOW(a_report_chan, out_valid && !out_kind, out_channel < wdc_pkg::CHAN_F_W'(wdc_pkg::CHANNELS), "report channel out of range")

    // an accepted item keeps the block busy for the next cycle
    `WDC_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready straight after a transfer")

endmodule

bind wiegand_door_controller_core wdc_checker u_wdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_in.valid),
    .in_ready    (i_in.ready),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .out_kind    (o_out.report_kind),
    .out_channel (o_out.report_channel),
    .out_card    (o_out.card_number),
    .out_lines   (o_out.door_lines),
    .out_last    (o_out.last)
);

@@ verif/tb_wiegand_door_controller_core.sv @@
// Testbench for the Wiegand door controller: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_wiegand_door_controller_core;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_SHOWN     = 10;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 18;

    // One result item as the block sends it
    typedef struct packed {
        logic                         report_kind;
        logic [wdc_pkg::CHAN_F_W-1:0] report_channel;
        logic [wdc_pkg::CARD_W-1:0]   card_number;
        logic [wdc_pkg::LINE_W-1:0]   door_lines;
        logic                         last;
    } t_report;

    // Predict card reports and door status, and hold the reports still to come
    class door_report_checker;
        wdc_pkg::t_cfg  cfg_st;
        wdc_pkg::t_chan chan_st [wdc_pkg::CHANNELS];
        t_report        pending_reports [$];
        int             errors;

        function new();
            cfg_st = wdc_pkg::CFG_RESET;
            foreach (chan_st[i]) chan_st[i] = wdc_pkg::CHAN_RESET;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_SHOWN) $display("%s", msg);
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void write_reg(wdc_pkg::t_reg idx, logic [wdc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                wdc_pkg::REG_GAP_LIMIT: cfg_st.gap_limit_ticks = data;
                wdc_pkg::REG_OPEN:      cfg_st.open_ticks = data;
                wdc_pkg::REG_VOTES:     cfg_st.button_votes = data[2:0];
                default: ;
            endcase
        endfunction

        function void open_door(int ch);
            chan_st[ch].door_line = 1'b1;
            chan_st[ch].door_hold_count = cfg_st.open_ticks;
        endfunction

        // Advance the channel state by one accepted item
        function void apply_item(logic [wdc_pkg::KIND_W-1:0] kind,
                                 logic [wdc_pkg::CHAN_F_W-1:0] ch,
                                 logic [wdc_pkg::LINE_W-1:0] btn, logic granted);
            wdc_pkg::t_op               op;
            logic [wdc_pkg::POS_W-1:0]  pos;
            logic [4:0]                 h;
            logic [wdc_pkg::LINE_W-1:0] lines;
            t_report                    tick_q [$];
            t_report                    r;
            op = wdc_pkg::t_op'(kind);
            case (op)
                wdc_pkg::OP_D0, wdc_pkg::OP_D1: begin
                    if (ch < wdc_pkg::CHANNELS) begin
                        // restart the frame after a long gap
                        if (chan_st[ch].idle_ticks > cfg_st.gap_limit_ticks)
                            chan_st[ch].bit_position = wdc_pkg::POS_TOP;
                        chan_st[ch].idle_ticks = '0;
                        pos = chan_st[ch].bit_position;
                        if (pos != wdc_pkg::POS_DONE && pos < wdc_pkg::FRAME_BITS) begin
                            chan_st[ch].frame_word[pos] = (op == wdc_pkg::OP_D1);
                            if (pos == 0) begin
                                chan_st[ch].frame_ready = 1'b1;
                                chan_st[ch].bit_position = wdc_pkg::POS_DONE;
                            end else begin
                                chan_st[ch].bit_position = pos - 1'b1;
                            end
                        end
                    end
                end
                wdc_pkg::OP_GRANT: begin
                    if (ch < wdc_pkg::CHANNELS && granted) open_door(ch);
                end
                wdc_pkg::OP_TICK: begin
                    for (int i = 0; i < wdc_pkg::CHANNELS; i++) begin
                        if (chan_st[i].frame_ready) begin
                            r.report_kind    = wdc_pkg::RPT_CARD;
                            r.report_channel = wdc_pkg::CHAN_F_W'(i);
                            r.card_number    = chan_st[i].frame_word[wdc_pkg::FRAME_BITS-2:1];
                            r.door_lines     = '0;
                            r.last           = 1'b0;
                            tick_q.push_back(r);
                            chan_st[i].frame_ready = 1'b0;
                        end
                        if (chan_st[i].idle_ticks != 8'hff)
                            chan_st[i].idle_ticks = chan_st[i].idle_ticks + 1'b1;
                        h = {chan_st[i].button_history[3:0],
                             (i < wdc_pkg::LINE_W) ? btn[i] : 1'b0};
                        chan_st[i].button_history = h;
                        if ($countones(h) >= cfg_st.button_votes) open_door(i);
                        // count down after any opening on this tick
                        if (chan_st[i].door_hold_count != 0) begin
                            chan_st[i].door_hold_count = chan_st[i].door_hold_count - 1'b1;
                            if (chan_st[i].door_hold_count == 0) chan_st[i].door_line = 1'b0;
                        end
                    end
                    lines = '0;
                    for (int i = 0; i < wdc_pkg::CHANNELS && i < wdc_pkg::LINE_W; i++)
                        lines[i] = chan_st[i].door_line;
                    r.report_kind    = wdc_pkg::RPT_STATUS;
                    r.report_channel = '0;
                    r.card_number    = '0;
                    r.door_lines     = '0;
                    r.last           = 1'b1;
                    tick_q.push_back(r);
                    foreach (tick_q[j]) begin
                        tick_q[j].door_lines = lines;
                        pending_reports.push_back(tick_q[j]);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one transfer on the result channel with the oldest prediction
        function void check_report(t_report got);
            t_report exp;
            if (pending_reports.size() == 0) begin
                flag($sformatf({"%0t: unexpected result kind=%0d ch=%0d card=%06h",
                     " lines=%02h last=%0d"}, $time, got.report_kind, got.report_channel,
                     got.card_number, got.door_lines, got.last));
                return;
            end
            exp = pending_reports.pop_front();
            if (got.report_kind !== exp.report_kind || got.report_channel !== exp.report_channel
                || got.card_number !== exp.card_number || got.door_lines !== exp.door_lines
                || got.last !== exp.last) begin
                flag($sformatf({"%0t: mismatch exp kind=%0d ch=%0d card=%06h lines=%02h last=%0d",
                     " got kind=%0d ch=%0d card=%06h lines=%02h last=%0d"}, $time,
                     exp.report_kind, exp.report_channel, exp.card_number, exp.door_lines,
                     exp.last, got.report_kind, got.report_channel, got.card_number,
                     got.door_lines, got.last));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    wdc_in_if  in_if ();
    wdc_out_if out_if ();
    wdc_cfg_if cfg_if ();

    wiegand_door_controller_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    door_report_checker tracker = new();

    bit steady   = 1'b0;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;
    int items_sent = 0;

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Give up on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Note every transfer on the three channels
    always @(posedge i_clk) begin
        t_report got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                tracker.apply_item(in_if.kind, in_if.channel, in_if.button_levels,
                                   in_if.granted);
            if (cfg_if.valid && cfg_if.ready)
                tracker.write_reg(wdc_pkg::t_reg'(cfg_if.index), cfg_if.data);
            if (out_if.valid && out_if.ready) begin
                got.report_kind    = out_if.report_kind;
                got.report_channel = out_if.report_channel;
                got.card_number    = out_if.card_number;
                got.door_lines     = out_if.door_lines;
                got.last           = out_if.last;
                tracker.check_report(got);
            end
        end
    end

    // Drive the result ready: random stalls, plus a long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                hold_left = LONG_HOLD - 1;
                out_if.ready = 1'b0;
            end else if (steady) begin
                out_if.ready = 1'b1;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Offer one item after a random gap, or none when steady, and hold it until the transfer
    task automatic send_item(wdc_pkg::t_op op, logic [wdc_pkg::CHAN_F_W-1:0] ch,
                             logic [wdc_pkg::LINE_W-1:0] btn, logic gr);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid         = 1'b1;
        in_if.kind          = op;
        in_if.channel       = ch;
        in_if.button_levels = btn;
        in_if.granted       = gr;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_pulse(logic [wdc_pkg::CHAN_F_W-1:0] ch, logic one);
        send_item(one ? wdc_pkg::OP_D1 : wdc_pkg::OP_D0, ch, wdc_pkg::LINE_W'($urandom),
                  1'($urandom));
    endtask

    task automatic send_tick(logic [wdc_pkg::LINE_W-1:0] btn);
        send_item(wdc_pkg::OP_TICK, wdc_pkg::CHAN_F_W'($urandom), btn, 1'($urandom));
    endtask

    task automatic send_grant(logic [wdc_pkg::CHAN_F_W-1:0] ch, logic gr);
        send_item(wdc_pkg::OP_GRANT, ch, wdc_pkg::LINE_W'($urandom), gr);
    endtask

    // Send a whole frame, top bit first, with ticks sprinkled in and optional extra pulses
    task automatic send_frame(int ch, int extra, int mode, int tick_pct);
        logic [wdc_pkg::FRAME_BITS-1:0] word;
        case (mode)
            1:       word = '1;
            2:       word = '0;
            default: word = wdc_pkg::FRAME_BITS'($urandom);
        endcase
        for (int b = wdc_pkg::FRAME_BITS - 1; b >= 0; b--) begin
            if ($urandom_range(0, 99) < tick_pct) send_tick(wdc_pkg::LINE_W'($urandom));
            send_pulse(wdc_pkg::CHAN_F_W'(ch), word[b]);
        end
        repeat (extra) send_pulse(wdc_pkg::CHAN_F_W'(ch), 1'($urandom));
    endtask

    // Mostly complete frames and button runs, the rest grants, broken frames and noise
    task automatic run_random(int count);
        int stop_at;
        int pick;
        int n;
        int k;
        int ch;
        logic [wdc_pkg::LINE_W-1:0] pattern;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_frame($urandom_range(0, wdc_pkg::CHANNELS - 1),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                           ($urandom_range(0, 5) > 1) ? 0 : $urandom_range(1, 2), 10);
                if ($urandom_range(0, 1)) send_tick(wdc_pkg::LINE_W'($urandom));
            end else if (pick < 65) begin
                n = $urandom_range(1, 6);
                pattern = wdc_pkg::LINE_W'($urandom);
                repeat (n)
                    send_tick(($urandom_range(0, 3) == 0) ? wdc_pkg::LINE_W'($urandom)
                                                          : pattern);
            end else if (pick < 75) begin
                send_grant(wdc_pkg::CHAN_F_W'($urandom_range(0, 7)), 1'($urandom));
            end else if (pick < 87) begin
                // broken frame, then sometimes enough ticks to force a restart
                ch = $urandom_range(0, wdc_pkg::CHANNELS - 1);
                n = $urandom_range(1, 12);
                repeat (n) send_pulse(wdc_pkg::CHAN_F_W'(ch), 1'($urandom));
                k = $urandom_range(0, 1) ? tracker.cfg_st.gap_limit_ticks + 1
                                         : $urandom_range(0, 2);
                if (k > 16) k = 2;
                repeat (k) send_tick(wdc_pkg::LINE_W'($urandom));
            end else begin
                ch = $urandom_range(0, 1) ? $urandom_range(wdc_pkg::CHANNELS, 7)
                                          : $urandom_range(0, 7);
                send_item(wdc_pkg::t_op'($urandom_range(0, 3)), wdc_pkg::CHAN_F_W'(ch),
                          wdc_pkg::LINE_W'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic write_cfg(wdc_pkg::t_reg idx, logic [wdc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Drop valid, wait for every predicted result, then let the last item settle
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [wdc_pkg::CFG_DATA_W-1:0] gap_v;
        logic [wdc_pkg::CFG_DATA_W-1:0] open_v;
        logic [wdc_pkg::CFG_DATA_W-1:0] votes_v;
        in_if.valid         = 1'b0;
        in_if.kind          = wdc_pkg::OP_D0;
        in_if.channel       = '0;
        in_if.button_levels = '0;
        in_if.granted       = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = wdc_pkg::REG_GAP_LIMIT;
        cfg_if.data         = '0;
        i_rst_n             = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every kind, channel and button extremes, ignored channels, votes
        send_tick('0);
        send_grant(0, 1'b1);
        send_grant(1, 1'b0);
        send_grant(7, 1'b1);
        send_grant(wdc_pkg::CHANNELS, 1'b1);
        send_pulse(wdc_pkg::CHANNELS, 1'b1);
        send_pulse(7, 1'b0);
        repeat (4) send_tick('1);
        repeat (3) send_pulse(5, 1'b1);
        repeat (2) send_pulse(5, 1'b0);
        send_tick(6'h15);
        send_tick(6'h2a);

        // Random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin gap_v = 8'd255; open_v = 8'd1;   votes_v = 8'd1;   end
                1: begin gap_v = 8'd0;   open_v = 8'd255; votes_v = 8'd5;   end
                2: begin gap_v = 8'd3;   open_v = 8'd0;   votes_v = 8'd0;   end
                3: begin gap_v = 8'd1;   open_v = 8'd7;   votes_v = 8'd6;   end
                4: begin
                    gap_v   = wdc_pkg::CFG_DATA_W'($urandom);
                    open_v  = wdc_pkg::CFG_DATA_W'($urandom);
                    votes_v = wdc_pkg::CFG_DATA_W'($urandom);
                end
                default: begin gap_v = 8'd2; open_v = 8'd40; votes_v = 8'hfc; end
            endcase
            write_cfg(wdc_pkg::REG_GAP_LIMIT, gap_v);
            write_cfg(wdc_pkg::REG_OPEN, open_v);
            write_cfg(wdc_pkg::REG_VOTES, votes_v);
            if (p == 3) begin
                write_cfg(wdc_pkg::REG_NONE, wdc_pkg::CFG_DATA_W'($urandom));
                write_cfg(wdc_pkg::REG_VOTES, 8'd7);
            end
            steady = (p == 2);
            // hold the result side off while items keep coming
            if (p == 1) hold_req = ~hold_req;
            if (p == PHASES - 1) begin
                // let the idle count pass the gap limit, then finish a frame that must restart
                steady = 1'b1;
                repeat (5) send_pulse(3, 1'($urandom));
                repeat (4) send_tick(wdc_pkg::LINE_W'($urandom));
                send_frame(3, 0, 0, 0);
                send_tick('0);
                steady = 1'b0;
            end
            run_random(PHASE_ITEMS);
        end

        drain();
        if (tracker.pending() != 0)
            tracker.flag($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ wiegand_door_controller_core.f @@
+incdir+hw/rtl
hw/rtl/wdc_pkg.sv
hw/rtl/wdc_if.sv
hw/rtl/wdc_chan_alu.sv
hw/rtl/wiegand_door_controller_core.sv
hw/rtl/wdc_checker.sv
verif/tb_wiegand_door_controller_core.sv
